>>> rtl/core/srf_pkg.sv
`timescale 1ns / 1ps

package srf_pkg;

    localparam logic [7:0] SYNC_BYTE      = 8'h80;
    localparam logic [7:0] LENGTH_CEILING = 8'd250;
    localparam logic [7:0] MAX_LENGTH_RST = 8'h85;
    localparam logic [2:0] SYNC_RUN_RST   = 3'd3;
    localparam logic [2:0] SYNC_SAT       = 3'd7;
    localparam logic [8:0] HEADER_BYTES   = 9'd4;

    typedef enum logic [0:0] {
        REG_MAX_LENGTH = 1'b0,
        REG_SYNC_RUN   = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_GOOD  = 2'd1,
        KIND_BAD   = 2'd2,
        KIND_ABORT = 2'd3
    } kind_t;

    // Effective configuration: values already clamped at write time.
    typedef struct packed {
        logic [7:0] length_limit;
        logic [2:0] sync_need;
    } cfg_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] byte_value;
        logic [7:0] position;
        logic       last_of_step;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } step_out_t;

endpackage

>>> rtl/core/srf_channels.sv
`timescale 1ns / 1ps

interface srf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface srf_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] byte_value;
    logic [7:0] position;
    logic       last_of_step;

    modport source (output valid, output kind, output byte_value, output position,
                    output last_of_step, input ready);
    modport sink (input valid, input kind, input byte_value, input position,
                  input last_of_step, output ready);
endinterface

interface srf_cfg_if;
    logic       valid;
    logic       ready;
    logic [0:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/srf_cfg.sv
`timescale 1ns / 1ps

module srf_cfg (
    input  logic           clk,
    input  logic           rst_n,
    srf_cfg_if.sink        cfg,
    output srf_pkg::cfg_t  cfg_q
);

    logic [7:0] limit_reg;
    logic [2:0] need_reg;
    logic [7:0] limit_next;
    logic [2:0] need_next;
    logic       wr;

    assign cfg.ready = 1'b1;
    assign wr        = cfg.valid;

    // Clamp on write so the datapath sees ready-to-use values.
    always_comb
    begin
        limit_next = limit_reg;
        need_next  = need_reg;
        if (wr)
        begin
            unique case (srf_pkg::reg_index_t'(cfg.index))
                srf_pkg::REG_MAX_LENGTH:
                begin
                    limit_next = (cfg.data > srf_pkg::LENGTH_CEILING) ?
                                 srf_pkg::LENGTH_CEILING : cfg.data;
                end
                srf_pkg::REG_SYNC_RUN:
                begin
                    need_next = (cfg.data[2:0] == 3'd0) ? 3'd1 : cfg.data[2:0];
                end
                default:
                begin
                    limit_next = limit_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= srf_pkg::MAX_LENGTH_RST;
            need_reg  <= srf_pkg::SYNC_RUN_RST;
        end
        else
        begin
            limit_reg <= limit_next;
            need_reg  <= need_next;
        end
    end

    assign cfg_q.length_limit = limit_reg;
    assign cfg_q.sync_need    = need_reg;

endmodule

>>> rtl/core/srf_step.sv
`timescale 1ns / 1ps

module srf_step (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [7:0]         rx_byte,
    input  srf_pkg::cfg_t      cfg_q,
    output srf_pkg::step_out_t step
);

    logic [2:0] sync_count_reg,     sync_count_next;
    logic       in_frame_reg,       in_frame_next;
    logic [7:0] frame_position_reg, frame_position_next;
    logic [7:0] frame_length_reg,   frame_length_next;
    logic [7:0] running_sum_reg,    running_sum_next;

    logic              is_sync;
    logic              opens;
    logic              fits;
    logic              at_checksum;
    srf_pkg::result_t  abort_res;
    srf_pkg::result_t  byte_res;

    assign is_sync     = (rx_byte == srf_pkg::SYNC_BYTE);
    assign opens       = !is_sync && (sync_count_reg >= cfg_q.sync_need);
    assign fits        = (rx_byte <= cfg_q.length_limit);
    assign at_checksum = ({1'b0, frame_position_reg} >=
                          ({1'b0, frame_length_reg} + srf_pkg::HEADER_BYTES));

    always_comb
    begin
        abort_res.kind         = srf_pkg::KIND_ABORT;
        abort_res.byte_value   = 8'd0;
        abort_res.position     = 8'd0;
        abort_res.last_of_step = 1'b0;

        byte_res.kind          = srf_pkg::KIND_BYTE;
        byte_res.byte_value    = rx_byte;
        byte_res.position      = frame_position_reg;
        byte_res.last_of_step  = 1'b1;

        sync_count_next     = sync_count_reg;
        in_frame_next       = in_frame_reg;
        frame_position_next = frame_position_reg;
        frame_length_next   = frame_length_reg;
        running_sum_next    = running_sum_reg;
        step.count          = 2'd0;
        step.first          = byte_res;
        step.second         = byte_res;

        if (is_sync)
        begin
            sync_count_next = (sync_count_reg == srf_pkg::SYNC_SAT) ?
                              srf_pkg::SYNC_SAT : (sync_count_reg + 3'd1);
        end
        else
        begin
            sync_count_next = 3'd0;
        end

        if (opens)
        begin
            // An abort, when present, always comes first.
            byte_res.position = 8'd0;
            if (in_frame_reg)
            begin
                in_frame_next       = 1'b0;
                frame_position_next = 8'd0;
                running_sum_next    = 8'd0;
                abort_res.last_of_step = !fits;
                step.first  = abort_res;
                step.second = byte_res;
                step.count  = fits ? 2'd2 : 2'd1;
            end
            else
            begin
                step.first = byte_res;
                step.count = fits ? 2'd1 : 2'd0;
            end
            if (fits)
            begin
                in_frame_next       = 1'b1;
                frame_length_next   = rx_byte;
                running_sum_next    = rx_byte;
                frame_position_next = 8'd1;
            end
        end
        else if (in_frame_reg)
        begin
            step.count = 2'd1;
            if (at_checksum)
            begin
                byte_res.kind = (running_sum_reg == rx_byte) ?
                                srf_pkg::KIND_GOOD : srf_pkg::KIND_BAD;
                in_frame_next       = 1'b0;
                frame_position_next = 8'd0;
                running_sum_next    = 8'd0;
            end
            else
            begin
                running_sum_next    = running_sum_reg + rx_byte;
                frame_position_next = frame_position_reg + 8'd1;
            end
            step.first = byte_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_count_reg     <= 3'd0;
            in_frame_reg       <= 1'b0;
            frame_position_reg <= 8'd0;
            frame_length_reg   <= 8'd0;
            running_sum_reg    <= 8'd0;
        end
        else if (accept)
        begin
            sync_count_reg     <= sync_count_next;
            in_frame_reg       <= in_frame_next;
            frame_position_reg <= frame_position_next;
            frame_length_reg   <= frame_length_next;
            running_sum_reg    <= running_sum_next;
        end
    end

endmodule

>>> rtl/core/srf_outq.sv
`timescale 1ns / 1ps

module srf_outq #(
    parameter int DEPTH = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  srf_pkg::step_out_t step,
    output logic               room,
    srf_result_if.source       res
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
    localparam logic [CW-1:0] ROOM_MIN  = CW'(DEPTH - 2);

    srf_pkg::result_t slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg,  count_next;
    logic [PW-1:0] wr_ptr_1, wr_ptr_2;
    logic [1:0]    n_push;
    logic          pop;

    assign wr_ptr_1 = (wr_ptr_reg == LAST_SLOT) ? '0 : (wr_ptr_reg + PW'(1));
    assign wr_ptr_2 = (wr_ptr_1 == LAST_SLOT) ? '0 : (wr_ptr_1 + PW'(1));
    assign n_push   = push ? step.count : 2'd0;
    assign pop      = res.valid && res.ready;
    // Room means at least two free slots, enough for the worst-case byte.
    assign room     = (count_reg <= ROOM_MIN);

    always_comb
    begin
        case (n_push)
            2'd1:    wr_ptr_next = wr_ptr_1;
            2'd2:    wr_ptr_next = wr_ptr_2;
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        rd_ptr_next = pop ? ((rd_ptr_reg == LAST_SLOT) ? '0 : (rd_ptr_reg + PW'(1)))
                          : rd_ptr_reg;
        count_next  = count_reg + CW'(n_push) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
        begin
            slot_reg[wr_ptr_reg] <= step.first;
        end
        if (n_push == 2'd2)
        begin
            slot_reg[wr_ptr_1] <= step.second;
        end
    end

    assign res.valid        = (count_reg != '0);
    assign res.kind         = slot_reg[rd_ptr_reg].kind;
    assign res.byte_value   = slot_reg[rd_ptr_reg].byte_value;
    assign res.position     = slot_reg[rd_ptr_reg].position;
    assign res.last_of_step = slot_reg[rd_ptr_reg].last_of_step;

endmodule

>>> rtl/core/sync_run_frame_receiver.sv
`timescale 1ns / 1ps

// Sync-run frame receiver. Received serial bytes enter on the rx channel, one
// item per byte. A run of at least sync_run bytes of 0x80 followed by another
// byte opens a frame whose length field is that byte, if that byte is at
// most max_length; each frame byte then leaves on the res channel with its
// kind and position, and the checksum byte closes the frame with a good or
// bad report. A sync run inside an open frame gives an abort item first. The
// cfg channel writes max_length (index 0) and sync_run (index 1); it is always
// ready, and the user must write it only while idle, which the block does not
// enforce. Results of a byte are registered on acceptance. Throughput: one
// byte per cycle while the queue has room. A byte gives zero, one or two
// items; the two-item case (abort plus new length) uses two entries, so the
// QUEUE_DEPTH entries set how long aborts are absorbed before rx.ready drops.
// Reset clears the framing state and empties the queue; max_length returns
// to 133 and sync_run to 3.
// When the receiver stalls res.ready, queued items hold in place; rx.ready
// falls once fewer than two queue slots remain and rises again as items leave.
module sync_run_frame_receiver #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    srf_byte_if.sink     rx,
    srf_result_if.source res,
    srf_cfg_if.sink      cfg
);

    srf_pkg::cfg_t      cfg_q;
    srf_pkg::step_out_t step;
    logic               room;
    logic               accept;

    // A byte is taken only when the queue can hold the worst case of two items.
    assign rx.ready = room;
    assign accept   = rx.valid && room;

    srf_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    // Framing state and the combinational per-byte decision.
    srf_step u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (rx.rx_byte),
        .cfg_q   (cfg_q),
        .step    (step)
    );

    // Result registers, organized as a small queue that decouples the sides.
    srf_outq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_outq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (accept),
        .step  (step),
        .room  (room),
        .res   (res)
    );

endmodule

>>> tb/sv/tb_sync_run_frame_receiver.sv
`timescale 1ns / 1ps

// Self-checking bench for the sync-run frame receiver. Received bytes go in on
// the rx channel, the checker pairs every result item with the oldest item that
// the software copy of the framing logic has queued, and the cfg channel is
// written only while the receiver is idle.
module tb_sync_run_frame_receiver;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 9;
    localparam int HOLD_CYCLES   = 90;    // long receiver hold-off for the backpressure test
    localparam int SETTLE_CYCLES = 4;     // wait in wait_idle after the last owed item
    localparam int DRAIN_CYCLES  = 10;
    localparam int QUIET_LIMIT   = 2000;  // cycles without any handshake before giving up
    localparam int MAX_REPORTS   = 10;

    logic clk;
    logic rst_n;

    srf_byte_if   rx_ch ();
    srf_result_if res_ch ();
    srf_cfg_if    cfg_ch ();

    sync_run_frame_receiver dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    // Copies of the raw written register values; eff_limit and eff_need clamp them.
    logic [7:0] max_len_r;
    logic [2:0] sync_run_r;

    // Framing state of the software copy.
    logic [2:0] sync_seen;
    logic       frame_open;
    logic [7:0] next_pos;
    logic [7:0] len_field;
    logic [7:0] csum;

    // Result items that the block still owes, oldest first.
    srf_pkg::result_t pending_results[$];

    int error_count;
    int items_sent;
    int quiet_cycles;
    int hold_left;
    int stall_left;
    bit src_gaps;
    bit sink_gaps;
    bit hold_req;

    always
    begin
        clk = 1'b0;
        #HALF_PERIOD;
        clk = 1'b1;
        #HALF_PERIOD;
    end

    // A max_length above the ceiling behaves as the ceiling, so every position
    // of a frame fits in eight bits.
    function automatic logic [7:0] eff_limit();
        return (max_len_r > srf_pkg::LENGTH_CEILING) ? srf_pkg::LENGTH_CEILING : max_len_r;
    endfunction

    // A sync_run of zero behaves as a run of one.
    function automatic int eff_need();
        return (sync_run_r == 3'd0) ? 1 : int'(sync_run_r);
    endfunction

    function automatic srf_pkg::result_t make_result(input srf_pkg::kind_t k,
                                                     input logic [7:0] v,
                                                     input logic [7:0] p);
        srf_pkg::result_t r;
        r.kind         = k;
        r.byte_value   = v;
        r.position     = p;
        r.last_of_step = 1'b0;
        return r;
    endfunction

    // Advances the framing state by one accepted byte and queues the result
    // items that byte must cause, flagging the final one of the step.
    function automatic void frame_model_step(input logic [7:0] b);
        srf_pkg::result_t outs[2];
        int               n;
        logic             opens;
        n     = 0;
        opens = 1'b0;

        // The run counter sees every byte, inside a frame or not.
        if (b == srf_pkg::SYNC_BYTE)
        begin
            if (sync_seen != srf_pkg::SYNC_SAT)
                sync_seen = sync_seen + 3'd1;
        end
        else
        begin
            opens     = (int'(sync_seen) >= eff_need());
            sync_seen = 3'd0;
        end

        if (opens)
        begin
            // A completed run wins over everything, the checksum slot included.
            if (frame_open)
            begin
                outs[n]    = make_result(srf_pkg::KIND_ABORT, 8'd0, 8'd0);
                n          = n + 1;
                frame_open = 1'b0;
                next_pos   = 8'd0;
                csum       = 8'd0;
            end
            if (b <= eff_limit())
            begin
                frame_open = 1'b1;
                len_field  = b;
                csum       = b;
                next_pos   = 8'd1;
                outs[n]    = make_result(srf_pkg::KIND_BYTE, b, 8'd0);
                n          = n + 1;
            end
        end
        else if (frame_open)
        begin
            if ({1'b0, next_pos} >= {1'b0, len_field} + srf_pkg::HEADER_BYTES)
            begin
                outs[n]    = make_result((csum == b) ? srf_pkg::KIND_GOOD : srf_pkg::KIND_BAD,
                                         b, next_pos);
                n          = n + 1;
                frame_open = 1'b0;
                next_pos   = 8'd0;
                csum       = 8'd0;
            end
            else
            begin
                outs[n]  = make_result(srf_pkg::KIND_BYTE, b, next_pos);
                n        = n + 1;
                csum     = csum + b;
                next_pos = next_pos + 8'd1;
            end
        end

        if (n > 0)
            outs[n - 1].last_of_step = 1'b1;
        for (int i = 0; i < n; i++)
            pending_results.insert(pending_results.size(), outs[i]);
    endfunction

    function automatic void log_mismatch(input string msg);
        error_count = error_count + 1;
        if (error_count <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    // Result checker: every accepted item must match the oldest one owed.
    always @(posedge clk)
    begin
        srf_pkg::result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                log_mismatch($sformatf("unexpected item kind %0d value %02h pos %0d last %b",
                                       res_ch.kind, res_ch.byte_value, res_ch.position,
                                       res_ch.last_of_step));
            end
            else
            begin
                want = pending_results.pop_front();
                if (res_ch.kind !== want.kind || res_ch.byte_value !== want.byte_value ||
                    res_ch.position !== want.position ||
                    res_ch.last_of_step !== want.last_of_step)
                begin
                    log_mismatch($sformatf({"expected kind %s value %02h pos %0d last %b, ",
                                            "got kind %0d value %02h pos %0d last %b"},
                                           want.kind.name(), want.byte_value, want.position,
                                           want.last_of_step, res_ch.kind, res_ch.byte_value,
                                           res_ch.position, res_ch.last_of_step));
                end
            end
        end
    end

    // Watchdog: a long stretch without any handshake means the block hung.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles = quiet_cycles + 1;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("simulation failed");
                    $finish;
                end
            end
        end
    end

    // Result receiver. It is ready by default, stalls in random bursts while
    // sink_gaps is set, and on request holds off for HOLD_CYCLES in a row so
    // that the block's queue fills and rx.ready drops. One assignment per
    // falling edge.
    initial
    begin
        res_ch.ready = 1'b0;
        hold_left    = 0;
        stall_left   = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                res_ch.ready = 1'b0;
                hold_left    = hold_left - 1;
            end
            else if (stall_left > 0)
            begin
                res_ch.ready = 1'b0;
                stall_left   = stall_left - 1;
            end
            else if (sink_gaps && $urandom_range(0, 11) == 0)
            begin
                res_ch.ready = 1'b0;
                stall_left   = $urandom_range(1, 18) - 1;
            end
            else
            begin
                res_ch.ready = 1'b1;
            end
        end
    end

    // Offers one byte, possibly after a random gap, and waits until it is taken.
    // The valid line stays high after acceptance so that back-to-back bytes go in
    // at one per cycle while rx.ready is high; the next call or wait_idle changes it.
    task automatic push_byte(input logic [7:0] b);
        int gap;
        if (src_gaps && $urandom_range(0, 9) == 0)
        begin
            gap = $urandom_range(1, 18);
            @(negedge clk);
            rx_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        rx_ch.valid   = 1'b1;
        rx_ch.rx_byte = b;
        do @(posedge clk); while (!rx_ch.ready);
        frame_model_step(b);
        items_sent = items_sent + 1;
    endtask

    task automatic push_sync(input int run);
        repeat (run) push_byte(srf_pkg::SYNC_BYTE);
    endtask

    // Sends a sync run, a length field and a frame body with random content.
    // With cut at zero or above at most that many bytes follow the length, which
    // leaves the frame open for a later run to abort. A length the block will drop
    // is followed by up to three stray bytes, plus a checksum if cut is below zero.
    task automatic send_frame(input int run, input logic [7:0] len, input bit good,
                              input int cut);
        logic [7:0] sum;
        logic [7:0] b;
        int         body;
        push_sync(run);
        push_byte(len);
        sum  = len;
        body = (len <= eff_limit()) ? int'(len) + 3 : $urandom_range(0, 3);
        if (cut >= 0 && cut < body)
            body = cut;
        for (int i = 0; i < body; i++)
        begin
            b = 8'($urandom_range(0, 255));
            push_byte(b);
            sum = sum + b;
        end
        if (cut < 0)
            push_byte(good ? sum : sum ^ 8'($urandom_range(1, 255)));
    endtask

    // Stops offering bytes and waits until the block has nothing left to say.
    // Bytes that cause no item may still be in flight, hence the extra cycles.
    task automatic wait_idle();
        @(negedge clk);
        rx_ch.valid = 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input srf_pkg::reg_index_t idx, input logic [7:0] value);
        wait_idle();
        @(negedge clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = value;
        do @(posedge clk); while (!cfg_ch.ready);
        if (idx == srf_pkg::REG_MAX_LENGTH)
            max_len_r = value;
        else
            sync_run_r = value[2:0];
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Reset settings: good and bad checksums, sync bytes inside a frame, idle
    // bytes, short runs and the length limit on both sides.
    task automatic test_basic_frames();
        // Shortest frame; 0x80 as command byte does not disturb framing.
        push_sync(3);
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'h80);
        push_byte(8'h7F);
        // One data byte, wrong checksum.
        push_sync(4);
        push_byte(8'h01);
        push_byte(8'h12);
        push_byte(8'h34);
        push_byte(8'h56);
        push_byte(8'hFF);
        push_byte(8'h9D);
        // Idle bytes and a run one short of the minimum give nothing.
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'h80);
        push_byte(8'h80);
        push_byte(8'h01);
        // Two sync bytes as data are passed out as frame bytes.
        push_sync(3);
        push_byte(8'h02);
        push_byte(8'h01);
        push_byte(8'h02);
        push_byte(8'h03);
        push_byte(8'h80);
        push_byte(8'h80);
        push_byte(8'h08);
        // Length exactly at the limit is taken, one above is dropped.
        send_frame(3, 8'd133, 1'b1, -1);
        send_frame(3, 8'd134, 1'b1, -1);
    endtask

    // A run completing inside an open frame aborts it, also when the opening
    // byte lands on the checksum slot.
    task automatic test_aborts();
        send_frame(3, 8'd5, 1'b1, 4);
        send_frame(3, 8'd2, 1'b1, -1);
        send_frame(3, 8'd1, 1'b1, 2);
        send_frame(3, 8'd200, 1'b1, 0);
        push_sync(3);
        push_byte(8'h03);
        push_byte(8'h10);
        push_byte(8'h20);
        push_byte(8'h30);
        push_sync(3);
        push_byte(8'h00);
        push_byte(8'hAA);
        push_byte(8'hBB);
        push_byte(8'hCC);
        push_byte(8'h31);
    endtask

    // Register extremes: zero length limit, limit above the ceiling, the
    // longest run with a saturating counter, and a run setting of zero.
    task automatic test_config_extremes();
        write_reg(srf_pkg::REG_MAX_LENGTH, 8'd0);
        write_reg(srf_pkg::REG_SYNC_RUN, 8'd1);
        send_frame(1, 8'd0, 1'b1, -1);
        send_frame(1, 8'd1, 1'b1, -1);

        write_reg(srf_pkg::REG_MAX_LENGTH, 8'hFF);
        write_reg(srf_pkg::REG_SYNC_RUN, 8'd7);
        push_sync(6);
        push_byte(8'h00);
        push_byte(8'h01);
        send_frame(10, 8'd250, 1'b1, -1);
        send_frame(7, 8'd251, 1'b1, -1);

        write_reg(srf_pkg::REG_SYNC_RUN, 8'hF8);
        write_reg(srf_pkg::REG_MAX_LENGTH, 8'd250);
        send_frame(1, 8'd7, 1'b0, -1);
        send_frame(2, 8'd3, 1'b1, -1);
    endtask

    // The receiver holds off for a long stretch while the sender keeps going
    // with aborted frames, each of which costs two result items.
    task automatic test_backpressure();
        write_reg(srf_pkg::REG_MAX_LENGTH, 8'd133);
        write_reg(srf_pkg::REG_SYNC_RUN, 8'd3);
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        hold_req  = 1'b1;
        repeat (8) send_frame(3, 8'($urandom_range(0, 6)), 1'b1, 2);
        send_frame(3, 8'd4, 1'b1, -1);
        wait_idle();
    endtask

    // Random traffic under one register setting: mostly well-formed frames
    // with random content, plus truncated frames, oversized lengths, runs one
    // short, and plain noise.
    task automatic run_phase(input int count, input logic [7:0] max_val,
                             input logic [7:0] sync_val, input bit gaps_on);
        int         target;
        int         pick;
        int         need;
        int         len_cap;
        logic [7:0] len;
        write_reg(srf_pkg::REG_MAX_LENGTH, max_val);
        write_reg(srf_pkg::REG_SYNC_RUN, sync_val);
        target    = items_sent + count;
        src_gaps  = gaps_on;
        sink_gaps = gaps_on;
        while (items_sent < target)
        begin
            // Now and then switch idling on or off to get quiet stretches too.
            if (gaps_on && $urandom_range(0, 15) == 0)
            begin
                src_gaps  = 1'($urandom_range(0, 1));
                sink_gaps = 1'($urandom_range(0, 1));
            end
            need    = eff_need();
            len_cap = (eff_limit() < 10) ? int'(eff_limit()) : 10;
            if ($urandom_range(0, 19) == 0)
                len = 8'($urandom_range(0, eff_limit()));
            else
                len = 8'($urandom_range(0, len_cap));
            pick = $urandom_range(0, 99);
            if (pick < 70)
                send_frame(need + $urandom_range(0, 2), len, $urandom_range(0, 3) != 0, -1);
            else if (pick < 80)
                send_frame(need + $urandom_range(0, 2), len, 1'b1,
                           $urandom_range(0, int'(len) + 3));
            else if (pick < 87)
                send_frame(need, 8'($urandom_range(int'(eff_limit()) + 1, 255)), 1'b1, -1);
            else if (pick < 94)
            begin
                push_sync(need - 1);
                repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic test_random_traffic();
        run_phase(125, 8'd133, 8'd3, 1'b1);
        run_phase(100, 8'd250, 8'd1, 1'b1);
        run_phase(100, 8'd0, 8'hFF, 1'b1);
        run_phase(100, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b1);
        run_phase(75, 8'hFF, 8'd2, 1'b1);
        // Closing stretch runs at full rate on both sides.
        run_phase(100, 8'd40, 8'd4, 1'b0);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = 8'h00;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = srf_pkg::REG_MAX_LENGTH;
        cfg_ch.data   = 8'h00;

        // The block comes out of reset with default registers and no frame.
        max_len_r  = srf_pkg::MAX_LENGTH_RST;
        sync_run_r = srf_pkg::SYNC_RUN_RST;
        sync_seen  = 3'd0;
        frame_open = 1'b0;
        next_pos   = 8'd0;
        len_field  = 8'd0;
        csum       = 8'd0;
        src_gaps   = 1'b1;
        sink_gaps  = 1'b1;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_basic_frames();
        test_aborts();
        test_config_extremes();
        test_backpressure();
        test_random_traffic();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
